FILE: rtl/sts_pkg.sv
package sts_pkg;

    // Internal counter widths.
    localparam int OFFSET_WIDTH = 16;
    localparam int LINE_WIDTH   = 16;

    // Widths of the result fields.
    localparam int KIND_WIDTH = 3;
    localparam int FIELD_WIDTH = 16;
    localparam logic [FIELD_WIDTH-1:0] LEN_MAX = '1;

    // Result queue geometry.
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_WIDTH   = $clog2(FIFO_DEPTH);
    localparam int COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);
    // One byte can cause at most two tokens, so room for two is required.
    localparam logic [COUNT_WIDTH-1:0] ROOM_LIMIT = COUNT_WIDTH'(FIFO_DEPTH - 2);

    // Scanner modes.
    localparam int MODE_WIDTH = 3;
    localparam logic [MODE_WIDTH-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_SLASH   = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_COMMENT = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_STRING  = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_INT     = 3'd4;
    localparam logic [MODE_WIDTH-1:0] MODE_DOT     = 3'd5;
    localparam logic [MODE_WIDTH-1:0] MODE_FRAC    = 3'd6;
    localparam logic [MODE_WIDTH-1:0] MODE_IDENT   = 3'd7;

    // Token kinds.
    localparam logic [KIND_WIDTH-1:0] KIND_SEMI   = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_EQUAL  = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_STRING = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_NUMBER = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_IDENT  = 3'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_VAR    = 3'd5;

    // Keyword matcher progress through "var".
    localparam logic [2:0] KW_NONE   = 3'd0;
    localparam logic [2:0] KW_V      = 3'd1;
    localparam logic [2:0] KW_VA     = 3'd2;
    localparam logic [2:0] KW_VAR    = 3'd3;
    localparam logic [2:0] KW_FAILED = 3'd7;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LOWER_V = 8'h76;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_R = 8'h72;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]  kind;
        logic [FIELD_WIDTH-1:0] start;
        logic [FIELD_WIDTH-1:0] length;
        logic [FIELD_WIDTH-1:0] line;
        logic                   last;
    } token_t;

    // Build a token from the scanner state; counters show their low bits.
    function automatic token_t make_token(
        logic [KIND_WIDTH-1:0]   kind,
        logic [OFFSET_WIDTH-1:0] start,
        logic [FIELD_WIDTH-1:0]  length,
        logic [LINE_WIDTH-1:0]   line
    );
        logic [OFFSET_WIDTH+FIELD_WIDTH-1:0] start_ext;
        logic [LINE_WIDTH+FIELD_WIDTH-1:0]   line_ext;
        token_t t;
        start_ext = {{FIELD_WIDTH{1'b0}}, start};
        line_ext  = {{FIELD_WIDTH{1'b0}}, line};
        t.kind    = kind;
        t.start   = start_ext[FIELD_WIDTH-1:0];
        t.length  = length;
        t.line    = line_ext[FIELD_WIDTH-1:0];
        t.last    = 1'b0;
        return t;
    endfunction

    // Saturating add of one or two bytes to the lexeme length.
    function automatic logic [FIELD_WIDTH-1:0] sat_len(
        logic [FIELD_WIDTH-1:0] length,
        logic [1:0]             step
    );
        logic [FIELD_WIDTH:0] sum;
        sum = {1'b0, length} + {{(FIELD_WIDTH-1){1'b0}}, step};
        return sum[FIELD_WIDTH] ? LEN_MAX : sum[FIELD_WIDTH-1:0];
    endfunction

endpackage

FILE: rtl/script_token_scanner_core.sv
// Streaming lexical scanner for a small script language.
//
// Input channel: one source byte per transfer (source_byte, end_of_source),
// handshake in_valid / in_stall. Setting end_of_source on a byte flushes the
// pending token after that byte and restarts offsets and line count.
// Output channel: one token per transfer (token_kind, start_offset,
// token_length, line_number, last_of_run), handshake out_valid / out_stall.
// last_of_run marks the final token caused by one source byte.
// Configuration: first_line is written when first_line_we is high; it also
// reloads the line count if no byte of the current source has been scanned.
//
// A byte is registered at its transfer and scanned from the input register
// once the token queue has room for two; its tokens are written into the
// queue and offered from its head. Throughput: one byte per cycle while the
// queue has room for two, set by the combinational scan step; a byte that
// causes two tokens takes two output transfers. A four-entry token queue
// separates the sides, so input transfers continue while the receiver stalls
// until fewer than two free entries remain. Reset empties the queue and
// returns the scanner to idle at offset zero with the line count at 1.
module script_token_scanner_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          first_line_we,
    input  logic [sts_pkg::FIELD_WIDTH-1:0] first_line,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    source_byte,
    input  logic                          end_of_source,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sts_pkg::KIND_WIDTH-1:0]  token_kind,
    output logic [sts_pkg::FIELD_WIDTH-1:0] start_offset,
    output logic [sts_pkg::FIELD_WIDTH-1:0] token_length,
    output logic [sts_pkg::FIELD_WIDTH-1:0] line_number,
    output logic                          last_of_run
);

    // Input register.
    logic       in_full_reg;
    logic [7:0] byte_reg;
    logic       eos_reg;

    // Scanner state.
    logic [sts_pkg::MODE_WIDTH-1:0]   mode_reg,  mode_next;
    logic [sts_pkg::OFFSET_WIDTH-1:0] pos_reg,   pos_next;
    logic [sts_pkg::OFFSET_WIDTH-1:0] start_reg, start_next;
    logic [sts_pkg::FIELD_WIDTH-1:0]  len_reg,   len_next;
    logic [2:0]                       kw_reg,    kw_next;
    logic [sts_pkg::LINE_WIDTH-1:0]   line_reg,  line_next;
    logic                             fresh_reg;
    logic [sts_pkg::FIELD_WIDTH-1:0]  first_line_reg;

    // Token queue.
    sts_pkg::token_t                 fifo_reg [sts_pkg::FIFO_DEPTH];
    logic [sts_pkg::PTR_WIDTH-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [sts_pkg::COUNT_WIDTH-1:0] count_reg;

    // Step results.
    sts_pkg::token_t tok [2];
    logic [1:0]      n_tok;
    logic            go_idle;
    logic            is_digit, is_alpha;
    logic            in_accept, process, pop;
    logic [sts_pkg::LINE_WIDTH+sts_pkg::FIELD_WIDTH-1:0] reg_line_ext, port_line_ext;
    logic [sts_pkg::LINE_WIDTH-1:0] reg_line, port_line;

    // Handshake control: the scan step runs when the queue has room for two.
    assign process   = in_full_reg && (count_reg <= sts_pkg::ROOM_LIMIT);
    assign in_stall  = in_full_reg && !process;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;

    // First line value at the line counter's width.
    assign reg_line_ext  = {{sts_pkg::LINE_WIDTH{1'b0}}, first_line_reg};
    assign port_line_ext = {{sts_pkg::LINE_WIDTH{1'b0}}, first_line};
    assign reg_line      = reg_line_ext[sts_pkg::LINE_WIDTH-1:0];
    assign port_line     = port_line_ext[sts_pkg::LINE_WIDTH-1:0];

    // Character classes of the registered byte.
    assign is_digit = byte_reg inside {[8'h30:8'h39]};
    assign is_alpha = byte_reg inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};

    // One scan step: finish the pending token, then rescan from idle if needed.
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        kw_next    = kw_reg;
        line_next  = line_reg;
        tok[0]     = '0;
        tok[1]     = '0;
        n_tok      = 2'd0;
        go_idle    = 1'b0;

        case (mode_reg)
            sts_pkg::MODE_SLASH:
            begin
                if (byte_reg == sts_pkg::CH_SLASH)
                begin
                    mode_next = sts_pkg::MODE_COMMENT;
                end
                else
                begin
                    go_idle = 1'b1;
                end
            end
            sts_pkg::MODE_COMMENT:
            begin
                if (byte_reg == sts_pkg::CH_NEWLINE)
                begin
                    line_next = line_next + sts_pkg::LINE_WIDTH'(1);
                    mode_next = sts_pkg::MODE_IDLE;
                end
            end
            sts_pkg::MODE_STRING:
            begin
                len_next = sts_pkg::sat_len(len_next, 2'd1);
                if (byte_reg == sts_pkg::CH_NEWLINE)
                begin
                    line_next = line_next + sts_pkg::LINE_WIDTH'(1);
                end
                if (byte_reg == sts_pkg::CH_QUOTE)
                begin
                    tok[0] = sts_pkg::make_token(sts_pkg::KIND_STRING, start_next,
                                                 len_next, line_next);
                    n_tok     = 2'd1;
                    mode_next = sts_pkg::MODE_IDLE;
                end
            end
            sts_pkg::MODE_INT:
            begin
                if (is_digit)
                begin
                    len_next = sts_pkg::sat_len(len_next, 2'd1);
                end
                else if (byte_reg == sts_pkg::CH_POINT)
                begin
                    mode_next = sts_pkg::MODE_DOT;
                end
                else
                begin
                    tok[0] = sts_pkg::make_token(sts_pkg::KIND_NUMBER, start_next,
                                                 len_next, line_next);
                    n_tok   = 2'd1;
                    go_idle = 1'b1;
                end
            end
            sts_pkg::MODE_DOT:
            begin
                if (is_digit)
                begin
                    // The point and this digit join the number together.
                    len_next  = sts_pkg::sat_len(len_next, 2'd2);
                    mode_next = sts_pkg::MODE_FRAC;
                end
                else
                begin
                    tok[0] = sts_pkg::make_token(sts_pkg::KIND_NUMBER, start_next,
                                                 len_next, line_next);
                    n_tok   = 2'd1;
                    go_idle = 1'b1;
                end
            end
            sts_pkg::MODE_FRAC:
            begin
                if (is_digit)
                begin
                    len_next = sts_pkg::sat_len(len_next, 2'd1);
                end
                else
                begin
                    tok[0] = sts_pkg::make_token(sts_pkg::KIND_NUMBER, start_next,
                                                 len_next, line_next);
                    n_tok   = 2'd1;
                    go_idle = 1'b1;
                end
            end
            sts_pkg::MODE_IDENT:
            begin
                if (is_alpha || is_digit)
                begin
                    len_next = sts_pkg::sat_len(len_next, 2'd1);
                    if (kw_reg == sts_pkg::KW_V && byte_reg == sts_pkg::CH_LOWER_A)
                    begin
                        kw_next = sts_pkg::KW_VA;
                    end
                    else if (kw_reg == sts_pkg::KW_VA && byte_reg == sts_pkg::CH_LOWER_R)
                    begin
                        kw_next = sts_pkg::KW_VAR;
                    end
                    else
                    begin
                        kw_next = sts_pkg::KW_FAILED;
                    end
                end
                else
                begin
                    tok[0] = sts_pkg::make_token(
                        (kw_reg == sts_pkg::KW_VAR) ? sts_pkg::KIND_VAR : sts_pkg::KIND_IDENT,
                        start_next, len_next, line_next);
                    n_tok   = 2'd1;
                    go_idle = 1'b1;
                end
            end
            default:
            begin
                go_idle = 1'b1;
            end
        endcase

        // Scan the byte from idle; this may start a token or emit one at once.
        if (go_idle)
        begin
            mode_next = sts_pkg::MODE_IDLE;
            case (byte_reg)
                sts_pkg::CH_SEMI, sts_pkg::CH_EQUAL:
                begin
                    start_next = pos_reg;
                    len_next   = sts_pkg::FIELD_WIDTH'(1);
                    tok[n_tok[0]] = sts_pkg::make_token(
                        (byte_reg == sts_pkg::CH_SEMI) ? sts_pkg::KIND_SEMI
                                                       : sts_pkg::KIND_EQUAL,
                        start_next, len_next, line_next);
                    n_tok = n_tok + 2'd1;
                end
                sts_pkg::CH_SLASH:
                begin
                    mode_next = sts_pkg::MODE_SLASH;
                end
                sts_pkg::CH_QUOTE:
                begin
                    mode_next  = sts_pkg::MODE_STRING;
                    start_next = pos_reg;
                    len_next   = sts_pkg::FIELD_WIDTH'(1);
                end
                sts_pkg::CH_NEWLINE:
                begin
                    line_next = line_next + sts_pkg::LINE_WIDTH'(1);
                end
                default:
                begin
                    if (is_digit)
                    begin
                        mode_next  = sts_pkg::MODE_INT;
                        start_next = pos_reg;
                        len_next   = sts_pkg::FIELD_WIDTH'(1);
                    end
                    else if (is_alpha)
                    begin
                        mode_next  = sts_pkg::MODE_IDENT;
                        start_next = pos_reg;
                        len_next   = sts_pkg::FIELD_WIDTH'(1);
                        kw_next    = (byte_reg == sts_pkg::CH_LOWER_V) ? sts_pkg::KW_V
                                                                       : sts_pkg::KW_FAILED;
                    end
                end
            endcase
        end

        pos_next = pos_reg + sts_pkg::OFFSET_WIDTH'(1);

        // End of source: flush the pending token and restart the scanner.
        if (eos_reg)
        begin
            if (mode_next == sts_pkg::MODE_STRING)
            begin
                tok[n_tok[0]] = sts_pkg::make_token(sts_pkg::KIND_STRING, start_next,
                                                    len_next, line_next);
                n_tok = n_tok + 2'd1;
            end
            else if (mode_next == sts_pkg::MODE_INT || mode_next == sts_pkg::MODE_DOT ||
                     mode_next == sts_pkg::MODE_FRAC)
            begin
                tok[n_tok[0]] = sts_pkg::make_token(sts_pkg::KIND_NUMBER, start_next,
                                                    len_next, line_next);
                n_tok = n_tok + 2'd1;
            end
            else if (mode_next == sts_pkg::MODE_IDENT)
            begin
                tok[n_tok[0]] = sts_pkg::make_token(
                    (kw_next == sts_pkg::KW_VAR) ? sts_pkg::KIND_VAR : sts_pkg::KIND_IDENT,
                    start_next, len_next, line_next);
                n_tok = n_tok + 2'd1;
            end
            mode_next  = sts_pkg::MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            kw_next    = sts_pkg::KW_NONE;
            line_next  = reg_line;
        end

        // Mark the final token of this byte.
        if (n_tok == 2'd1)
        begin
            tok[0].last = 1'b1;
        end
        else if (n_tok == 2'd2)
        begin
            tok[1].last = 1'b1;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (process)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= source_byte;
            eos_reg  <= end_of_source;
        end
    end

    // Scanner state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= sts_pkg::MODE_IDLE;
            pos_reg        <= '0;
            start_reg      <= '0;
            len_reg        <= '0;
            kw_reg         <= sts_pkg::KW_NONE;
            line_reg       <= sts_pkg::LINE_WIDTH'(1);
            fresh_reg      <= 1'b1;
            first_line_reg <= sts_pkg::FIELD_WIDTH'(1);
        end
        else
        begin
            if (first_line_we)
            begin
                first_line_reg <= first_line;
            end
            if (process)
            begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                kw_reg    <= kw_next;
                line_reg  <= line_next;
                fresh_reg <= eos_reg;
            end
            else if (first_line_we && fresh_reg)
            begin
                line_reg <= port_line;
            end
        end
    end

    // Token queue storage.
    always_ff @(posedge clk)
    begin
        if (process && n_tok != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= tok[0];
        end
        if (process && n_tok == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + sts_pkg::PTR_WIDTH'(1)] <= tok[1];
        end
    end

    // Token queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (process)
            begin
                wr_ptr_reg <= wr_ptr_reg + sts_pkg::PTR_WIDTH'(n_tok);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + sts_pkg::PTR_WIDTH'(1);
            end
            count_reg <= count_reg
                       + (process ? sts_pkg::COUNT_WIDTH'(n_tok) : '0)
                       - sts_pkg::COUNT_WIDTH'(pop);
        end
    end

    // Output fields come straight from the head of the queue.
    assign token_kind   = fifo_reg[rd_ptr_reg].kind;
    assign start_offset = fifo_reg[rd_ptr_reg].start;
    assign token_length = fifo_reg[rd_ptr_reg].length;
    assign line_number  = fifo_reg[rd_ptr_reg].line;
    assign last_of_run  = fifo_reg[rd_ptr_reg].last;

    // The queue never holds more tokens than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sts_pkg::COUNT_WIDTH'(sts_pkg::FIFO_DEPTH))
        else $error("token queue overflow");

    // A byte that ends the source leaves the scanner idle at offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        process && eos_reg |=> mode_reg == sts_pkg::MODE_IDLE && pos_reg == '0)
        else $error("scanner did not restart after end of source");

    // An identifier in progress always carries a keyword match state.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == sts_pkg::MODE_IDENT |-> kw_reg != sts_pkg::KW_NONE)
        else $error("identifier without keyword match state");

endmodule
